// ----- design/bpfm_pkg.sv -----
// ----------------------------------------------------------------------------
// bpfm_pkg
// Shared types and constants of the buffer pool frame manager.
// ----------------------------------------------------------------------------
package bpfm_pkg;

  localparam int NUM_FRAMES = 8;
  localparam int PAGE_BITS  = 16;
  localparam int PIN_BITS   = 8;
  localparam int FR_BITS    = $clog2(NUM_FRAMES);
  localparam int CNT_BITS   = $clog2(NUM_FRAMES + 1);

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [PIN_BITS-1:0]  pin_t;
  typedef logic [FR_BITS-1:0]   frame_t;

  typedef enum logic [2:0] {
    OP_PIN   = 3'd0,
    OP_UNPIN = 3'd1,
    OP_DIRTY = 3'd2,
    OP_FORCE = 3'd3,
    OP_FLUSH = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOTFOUND = 3'd1,
    ST_PINZERO  = 3'd2,
    ST_ALLPIN   = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    REG_POLICY = 1'd0,
    REG_FRAMES = 1'd1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_PIN,
    S_FLUSH,
    S_OUT
  } state_t;

  // Command from the controller to every frame cell.
  typedef struct packed {
    logic   wr;
    frame_t idx;
    logic   set_valid;
    logic   set_page;
    page_t  page;
    logic   set_dirty;
    logic   dirty;
    logic   set_pins;
    pin_t   pins;
  } cell_cmd_t;

  // Status a frame cell reports back.
  typedef struct packed {
    logic  valid;
    logic  dirty;
    page_t page;
    pin_t  pins;
  } cell_stat_t;

  // Queue shift command.
  typedef struct packed {
    logic   move;
    frame_t frame;
  } q_cmd_t;

endpackage

// ----- design/buffer_pool_frame_manager.sv -----
// ----------------------------------------------------------------------------
// buffer_pool_frame_manager
// Frame table of a page buffer pool with FIFO or LRU replacement.
// A non-flush request passes through the lookup and pin states before its result
// is shown; a flush scans one frame per cycle, pausing to show a result for each
// frame it writes back, plus output stalls.
// Throughput: one item at a time; a new request waits for the last result.
// Reset: synchronous, clears all frames, counters and restores queue order.
// ----------------------------------------------------------------------------
module buffer_pool_frame_manager (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [15:0] in_page_num,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [2:0]  out_frame_index,
  output logic        out_read_request,
  output logic [15:0] out_read_page,
  output logic        out_write_request,
  output logic [15:0] out_write_page,
  output logic        out_last_result,
  output logic [31:0] out_read_io_count,
  output logic [31:0] out_write_io_count,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [3:0]  cfg_data
);
  import bpfm_pkg::*;

  state_t state_r, state_nxt;
  logic   policy_r;
  logic [3:0] fiu_r;
  logic [2:0] op_r;
  page_t  page_r;
  logic [31:0] rd_cnt_r, wr_cnt_r, rd_cnt_nxt, wr_cnt_nxt;
  frame_t scan_r, scan_nxt;
  logic   any_r, any_nxt;

  // output register
  logic [2:0] o_st_r, o_st_nxt;
  frame_t o_fr_r, o_fr_nxt;
  logic o_rd_r, o_rd_nxt, o_wr_r, o_wr_nxt, o_last_r, o_last_nxt;
  page_t o_rp_r, o_rp_nxt, o_wp_r, o_wp_nxt;

  // lookup results registered
  logic   hit_r;
  frame_t hit_idx_r;
  logic   empty_r;
  frame_t empty_idx_r;
  logic   vic_r;
  frame_t vic_idx_r;

  cell_cmd_t  ccmd;
  cell_stat_t cstat [NUM_FRAMES];
  q_cmd_t     qcmd;
  frame_t     qval  [NUM_FRAMES];
  logic       qhit  [NUM_FRAMES];

  logic [CNT_BITS-1:0] n_act;
  always_comb begin
    if (fiu_r == 4'd0) n_act = CNT_BITS'(1);
    else if ({1'b0, fiu_r} > 5'(NUM_FRAMES)) n_act = CNT_BITS'(NUM_FRAMES);
    else n_act = CNT_BITS'(fiu_r);
  end

  genvar g;
  generate
    for (g = 0; g < NUM_FRAMES; g++) begin : g_cell
      bpfm_frame_cell u_fc (
        .clk(clk), .rst_n(rst_n), .my_idx(frame_t'(g)), .cmd(ccmd), .stat(cstat[g])
      );
      bpfm_queue_cell u_qc (
        .clk(clk), .rst_n(rst_n), .rst_val(frame_t'(g)), .cmd(qcmd),
        .is_tail(g == NUM_FRAMES - 1),
        .hit_left((g == 0) ? 1'b0 : qhit[(g == 0) ? 0 : g - 1]),
        .right_val(qval[(g == NUM_FRAMES - 1) ? g : g + 1]),
        .val(qval[g]), .hit_out(qhit[g])
      );
    end
  endgenerate

  // combinational searches over the eight cells
  logic   hit_c, empty_c, vic_c;
  frame_t hit_c_idx, empty_c_idx, vic_c_idx;
  always_comb begin
    hit_c = 1'b0; hit_c_idx = '0;
    empty_c = 1'b0; empty_c_idx = '0;
    vic_c = 1'b0; vic_c_idx = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if (CNT_BITS'(i) < n_act) begin
        if (cstat[i].valid && cstat[i].page == page_r) begin
          hit_c = 1'b1; hit_c_idx = frame_t'(i);
        end
        if (!cstat[i].valid) begin
          empty_c = 1'b1; empty_c_idx = frame_t'(i);
        end
      end
    end
    for (int p = NUM_FRAMES - 1; p >= 0; p--) begin
      if ({1'b0, qval[p]} < n_act && cstat[qval[p]].pins == '0) begin
        vic_c = 1'b1; vic_c_idx = qval[p];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_LOOK) begin
      hit_r <= hit_c; hit_idx_r <= hit_c_idx;
      empty_r <= empty_c; empty_idx_r <= empty_c_idx;
      vic_r <= vic_c; vic_idx_r <= vic_c_idx;
    end
  end

  cell_stat_t hs, vs, fs;
  logic flush_hit;
  assign hs = cstat[hit_idx_r];
  assign vs = cstat[vic_idx_r];
  assign fs = cstat[scan_r];
  assign flush_hit = ({1'b0, scan_r} < n_act) && fs.valid && fs.dirty && fs.pins == '0;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    ccmd = '0;
    qcmd = '0;
    rd_cnt_nxt = rd_cnt_r;
    wr_cnt_nxt = wr_cnt_r;
    scan_nxt = scan_r;
    any_nxt = any_r;
    o_st_nxt = o_st_r; o_fr_nxt = o_fr_r; o_rd_nxt = o_rd_r; o_rp_nxt = o_rp_r;
    o_wr_nxt = o_wr_r; o_wp_nxt = o_wp_r; o_last_nxt = o_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          scan_nxt = '0;
          any_nxt = 1'b0;
          state_nxt = (in_opcode == OP_FLUSH) ? S_FLUSH : S_LOOK;
        end
      end
      S_LOOK: begin
        state_nxt = S_PIN;
      end
      S_PIN: begin
        o_st_nxt = ST_OK; o_fr_nxt = '0; o_rd_nxt = 1'b0; o_rp_nxt = '0;
        o_wr_nxt = 1'b0; o_wp_nxt = '0; o_last_nxt = 1'b1;
        state_nxt = S_OUT;
        ccmd.idx = hit_idx_r;
        priority case (op_r)
          OP_PIN: begin
            if (hit_r) begin
              o_fr_nxt = hit_idx_r;
              if (hs.pins == {PIN_BITS{1'b1}}) begin
                o_st_nxt = ST_OVERFLOW;
              end else begin
                ccmd.wr = 1'b1; ccmd.set_pins = 1'b1; ccmd.pins = hs.pins + 1'b1;
                qcmd.move = policy_r; qcmd.frame = hit_idx_r;
              end
            end else if (empty_r) begin
              o_fr_nxt = empty_idx_r; o_rd_nxt = 1'b1; o_rp_nxt = page_r;
              ccmd.wr = 1'b1; ccmd.idx = empty_idx_r;
              ccmd.set_valid = 1'b1; ccmd.set_page = 1'b1; ccmd.page = page_r;
              ccmd.set_dirty = 1'b1; ccmd.dirty = 1'b0;
              ccmd.set_pins = 1'b1; ccmd.pins = pin_t'(1);
              rd_cnt_nxt = rd_cnt_r + 32'd1;
            end else if (vic_r) begin
              o_fr_nxt = vic_idx_r; o_rd_nxt = 1'b1; o_rp_nxt = page_r;
              if (vs.dirty) begin
                o_wr_nxt = 1'b1; o_wp_nxt = vs.page;
                wr_cnt_nxt = wr_cnt_r + 32'd1;
              end
              ccmd.wr = 1'b1; ccmd.idx = vic_idx_r;
              ccmd.set_valid = 1'b1; ccmd.set_page = 1'b1; ccmd.page = page_r;
              ccmd.set_dirty = 1'b1; ccmd.dirty = 1'b0;
              ccmd.set_pins = 1'b1; ccmd.pins = pin_t'(1);
              rd_cnt_nxt = rd_cnt_r + 32'd1;
              qcmd.move = 1'b1; qcmd.frame = vic_idx_r;
            end else begin
              o_st_nxt = ST_ALLPIN;
            end
          end
          OP_UNPIN: begin
            if (!hit_r) o_st_nxt = ST_NOTFOUND;
            else begin
              o_fr_nxt = hit_idx_r;
              if (hs.pins == '0) o_st_nxt = ST_PINZERO;
              else begin
                ccmd.wr = 1'b1; ccmd.set_pins = 1'b1; ccmd.pins = hs.pins - 1'b1;
              end
            end
          end
          OP_DIRTY: begin
            if (!hit_r) o_st_nxt = ST_NOTFOUND;
            else begin
              o_fr_nxt = hit_idx_r;
              ccmd.wr = 1'b1; ccmd.set_dirty = 1'b1; ccmd.dirty = 1'b1;
            end
          end
          OP_FORCE: begin
            if (!hit_r) o_st_nxt = ST_NOTFOUND;
            else begin
              o_fr_nxt = hit_idx_r; o_wr_nxt = 1'b1; o_wp_nxt = hs.page;
              wr_cnt_nxt = wr_cnt_r + 32'd1;
              ccmd.wr = 1'b1; ccmd.set_dirty = 1'b1; ccmd.dirty = 1'b0;
            end
          end
          default: ;
        endcase
      end
      S_FLUSH: begin
        // one frame per cycle, paused while a result is shown; emits on a dirty unpinned frame
        o_st_nxt = ST_OK; o_rd_nxt = 1'b0; o_rp_nxt = '0;
        if (flush_hit) begin
          o_fr_nxt = scan_r; o_wr_nxt = 1'b1; o_wp_nxt = fs.page;
          wr_cnt_nxt = wr_cnt_r + 32'd1;
          ccmd.wr = 1'b1; ccmd.idx = scan_r; ccmd.set_dirty = 1'b1; ccmd.dirty = 1'b0;
          any_nxt = 1'b1;
          o_last_nxt = ({1'b0, scan_r} + 1'b1 >= {1'b0, n_act});
          scan_nxt = scan_r + 1'b1;
          state_nxt = S_OUT;
        end else if ({1'b0, scan_r} + 1'b1 >= {1'b0, n_act}) begin
          o_fr_nxt = '0; o_wr_nxt = 1'b0; o_wp_nxt = '0; o_last_nxt = 1'b1;
          if (any_r) begin
            // previous result was not flagged last; emit nothing more
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_OUT;
          end
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          if (o_last_r) state_nxt = S_IDLE;
          else state_nxt = S_FLUSH;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // A flush can only end on a result when the last frame is known in advance,
  // so look ahead: the result is last if no later frame qualifies.
  logic later_hit;
  always_comb begin
    later_hit = 1'b0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (frame_t'(i) > scan_r && CNT_BITS'(i) < n_act &&
          cstat[i].valid && cstat[i].dirty && cstat[i].pins == '0)
        later_hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      policy_r <= 1'b0;
      fiu_r    <= 4'd8;
      rd_cnt_r <= '0;
      wr_cnt_r <= '0;
      scan_r   <= '0;
      any_r    <= 1'b0;
      o_last_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      wr_cnt_r <= wr_cnt_nxt;
      scan_r   <= scan_nxt;
      any_r    <= any_nxt;
      if (state_r == S_FLUSH && flush_hit) o_last_r <= !later_hit;
      else o_last_r <= o_last_nxt;
      if (cfg_we) begin
        if (cfg_index == 4'(REG_POLICY)) policy_r <= cfg_data[0];
        else if (cfg_index == 4'(REG_FRAMES)) fiu_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r   <= in_opcode;
      page_r <= in_page_num;
    end
    o_st_r <= o_st_nxt; o_fr_r <= o_fr_nxt; o_rd_r <= o_rd_nxt; o_rp_r <= o_rp_nxt;
    o_wr_r <= o_wr_nxt; o_wp_r <= o_wp_nxt;
  end

  assign out_status         = o_st_r;
  assign out_frame_index    = o_fr_r;
  assign out_read_request   = o_rd_r;
  assign out_read_page      = o_rp_r;
  assign out_write_request  = o_wr_r;
  assign out_write_page     = o_wp_r;
  assign out_last_result    = o_last_r;
  assign out_read_io_count  = rd_cnt_r;
  assign out_write_io_count = wr_cnt_r;
endmodule

// ----- design/bpfm_frame_cell.sv -----
// ----------------------------------------------------------------------------
// bpfm_frame_cell
// One frame entry: page, valid, dirty and pin count.
// ----------------------------------------------------------------------------
module bpfm_frame_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bpfm_pkg::frame_t      my_idx,
  input  bpfm_pkg::cell_cmd_t   cmd,
  output bpfm_pkg::cell_stat_t  stat
);
  import bpfm_pkg::*;

  logic  valid_r, dirty_r;
  page_t page_r;
  pin_t  pins_r;
  logic  sel;

  assign sel = cmd.wr && (cmd.idx == my_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dirty_r <= 1'b0;
      page_r  <= '0;
      pins_r  <= '0;
    end else if (sel) begin
      if (cmd.set_valid) valid_r <= 1'b1;
      if (cmd.set_page)  page_r  <= cmd.page;
      if (cmd.set_dirty) dirty_r <= cmd.dirty;
      if (cmd.set_pins)  pins_r  <= cmd.pins;
    end
  end

  assign stat = '{valid: valid_r, dirty: dirty_r, page: page_r, pins: pins_r};
endmodule

// ----- design/bpfm_queue_cell.sv -----
// ----------------------------------------------------------------------------
// bpfm_queue_cell
// One slot of the replacement order queue. On a move, slots at and after
// the moved frame take their right neighbor; the tail takes the frame.
// ----------------------------------------------------------------------------
module bpfm_queue_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  bpfm_pkg::frame_t  rst_val,
  input  bpfm_pkg::q_cmd_t  cmd,
  input  logic              is_tail,
  input  logic              hit_left,
  input  bpfm_pkg::frame_t  right_val,
  output bpfm_pkg::frame_t  val,
  output logic              hit_out
);
  import bpfm_pkg::*;

  frame_t val_r;
  logic   shift;

  assign hit_out = hit_left || (val_r == cmd.frame);
  assign shift   = cmd.move && hit_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= rst_val;
    end else if (shift) begin
      val_r <= is_tail ? cmd.frame : right_val;
    end
  end

  assign val = val_r;
endmodule
